/* rtl/core/dpsd_pkg.sv */
// Shared types, constants and field-form functions for the delta pair stream decoder.
package dpsd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned PTR_W      = 5;
    localparam int unsigned COUNT_W    = 32;

    // Register indexes of the configuration port.
    localparam logic CFG_POINTER_BYTES = 1'b0;
    localparam logic CFG_PAIR_COUNT    = 1'b1;

    localparam logic [PTR_W-1:0] POINTER_BYTES_RESET = 5'd8;

    // Highest legal id form code in the low nibble of a type byte.
    localparam logic [3:0] ID_FORM_MAX = 4'd7;

    typedef enum logic [2:0] {
        FORM_RAW   = 3'd0,
        FORM_INC   = 3'd1,
        FORM_ADD8  = 3'd2,
        FORM_SUB8  = 3'd3,
        FORM_ADD16 = 3'd4,
        FORM_SUB16 = 3'd5,
        FORM_ABS16 = 3'd6,
        FORM_ABS32 = 3'd7
    } form_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_type;
        logic load_byte;
        logic finish_id;
        logic div_start;
        logic calc;
        logic emit;
        logic emit_bad;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic type_bad;
        logic type_id_empty;
        logic id_done;
        logic off_done;
        logic off_empty;
        logic scaled;
        logic div_done;
    } dp_status_t;

    // Number of operand bytes that follow for a field form.
    function automatic logic [3:0] form_len(input logic [2:0] form);
        logic [3:0] len;
        unique case (form_t'(form)) inside
            FORM_RAW:                          len = 4'd8;
            FORM_INC:                          len = 4'd0;
            FORM_ADD8, FORM_SUB8:              len = 4'd1;
            FORM_ADD16, FORM_SUB16, FORM_ABS16: len = 4'd2;
            FORM_ABS32:                        len = 4'd4;
            default:                           len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [VALUE_W-1:0] apply_form(
        input logic [2:0]         form,
        input logic [VALUE_W-1:0] prev,
        input logic [VALUE_W-1:0] v
    );
        logic [VALUE_W-1:0] res;
        unique case (form_t'(form)) inside
            FORM_INC:              res = prev + 64'd1;
            FORM_ADD8, FORM_ADD16: res = prev + v;
            FORM_SUB8, FORM_SUB16: res = prev - v;
            default:               res = v;
        endcase
        return res;
    endfunction

endpackage

/* rtl/core/dpsd_divider.sv */
// Iterative divider of a 64-bit value by a 5-bit divisor, eight quotient bits per cycle.
module dpsd_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dpsd_pkg::VALUE_W-1:0] dividend,
    input  logic [dpsd_pkg::PTR_W-1:0]   divisor,
    output logic [dpsd_pkg::VALUE_W-1:0] quotient,
    output logic                         done
);
    import dpsd_pkg::*;

    localparam int unsigned BITS_PER_CYCLE = 8;
    localparam int unsigned CYCLES         = VALUE_W / BITS_PER_CYCLE;
    localparam int unsigned CNT_W          = $clog2(CYCLES);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(CYCLES - 1);

    logic [VALUE_W-1:0]        num_reg;
    logic [VALUE_W-1:0]        quot_reg;
    logic [PTR_W-1:0]          rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [PTR_W-1:0]          rem_next;
    logic [BITS_PER_CYCLE-1:0] qbits;

    // Restoring division; the remainder always stays below the divisor.
    always_comb
    begin
        logic [PTR_W:0] trial;
        rem_next = rem_reg;
        qbits    = '0;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            trial = {rem_next, num_reg[VALUE_W-1-i]};
            if (trial >= {1'b0, divisor})
            begin
                qbits[BITS_PER_CYCLE-1-i] = 1'b1;
                rem_next = PTR_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[PTR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                num_reg  <= dividend;
                quot_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg  <= num_reg << BITS_PER_CYCLE;
                quot_reg <= {quot_reg[VALUE_W-BITS_PER_CYCLE-1:0], qbits};
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

/* rtl/core/dpsd_datapath.sv */
// Datapath: configuration registers, field accumulation, id and offset arithmetic, result register.
module dpsd_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dpsd_pkg::dp_cmd_t               cmd,
    output dpsd_pkg::dp_status_t            status,
    input  logic [dpsd_pkg::BYTE_W-1:0]     stream_byte,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [dpsd_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [dpsd_pkg::VALUE_W-1:0]    decoded_id,
    output logic [dpsd_pkg::VALUE_W-1:0]    decoded_offset,
    output logic                            bad_type,
    output logic                            last_pair
);
    import dpsd_pkg::*;

    logic [PTR_W-1:0]   pointer_bytes_reg;
    logic [COUNT_W-1:0] pair_count_reg;
    logic [BYTE_W-1:0]  record_type_reg;
    logic [2:0]         byte_index_reg;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] prev_id_reg;
    logic [VALUE_W-1:0] prev_off_reg;
    logic [VALUE_W-1:0] cur_id_reg;
    logic [COUNT_W-1:0] records_done_reg;
    logic [VALUE_W-1:0] off_pre_reg;
    logic [VALUE_W-1:0] out_id_reg;
    logic [VALUE_W-1:0] out_off_reg;
    logic               out_bad_reg;
    logic               out_last_reg;

    logic [PTR_W-1:0]         divisor;
    logic [VALUE_W-1:0]       quotient;
    logic                     div_done;
    logic [VALUE_W-1:0]       off_base;
    logic [VALUE_W+PTR_W-1:0] product;
    logic [VALUE_W-1:0]       off_final;
    logic [COUNT_W-1:0]       records_done_next;
    logic [3:0]               index_plus_one;

    // A pointer size of zero behaves as one.
    assign divisor = (pointer_bytes_reg == '0) ? PTR_W'(1) : pointer_bytes_reg;

    dpsd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prev_off_reg),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    assign index_plus_one = {1'b0, byte_index_reg} + 4'd1;

    assign status.type_bad      = stream_byte[3:0] > ID_FORM_MAX;
    assign status.type_id_empty = form_len(stream_byte[2:0]) == 4'd0;
    assign status.id_done       = index_plus_one >= form_len(record_type_reg[2:0]);
    assign status.off_done      = index_plus_one >= form_len(record_type_reg[6:4]);
    assign status.off_empty     = form_len(record_type_reg[6:4]) == 4'd0;
    assign status.scaled        = record_type_reg[7];
    assign status.div_done      = div_done;

    assign off_base          = record_type_reg[7] ? quotient : prev_off_reg;
    assign product           = off_pre_reg * divisor;
    assign off_final         = record_type_reg[7] ? product[VALUE_W-1:0] : off_pre_reg;
    assign records_done_next = records_done_reg + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_bytes_reg <= POINTER_BYTES_RESET;
            pair_count_reg    <= '0;
            record_type_reg   <= '0;
            byte_index_reg    <= '0;
            acc_reg           <= '0;
            prev_id_reg       <= '0;
            prev_off_reg      <= '0;
            cur_id_reg        <= '0;
            records_done_reg  <= '0;
            off_pre_reg       <= '0;
            out_id_reg        <= '0;
            out_off_reg       <= '0;
            out_bad_reg       <= 1'b0;
            out_last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POINTER_BYTES: pointer_bytes_reg <= cfg_data[PTR_W-1:0];
                    CFG_PAIR_COUNT:    pair_count_reg    <= cfg_data[COUNT_W-1:0];
                    default:           pair_count_reg    <= pair_count_reg;
                endcase
            end

            if (cmd.load_type)
            begin
                record_type_reg <= stream_byte;
                acc_reg         <= '0;
                byte_index_reg  <= '0;
            end

            // Fields are little-endian; the accumulator is clear at field start.
            if (cmd.load_byte)
            begin
                acc_reg[{byte_index_reg, 3'b000} +: BYTE_W] <= stream_byte;
                byte_index_reg <= byte_index_reg + 3'd1;
            end

            if (cmd.finish_id)
            begin
                cur_id_reg     <= apply_form(record_type_reg[2:0], prev_id_reg, acc_reg);
                acc_reg        <= '0;
                byte_index_reg <= '0;
            end

            if (cmd.calc)
            begin
                off_pre_reg <= apply_form(record_type_reg[6:4], off_base, acc_reg);
            end

            if (cmd.emit)
            begin
                out_id_reg       <= cur_id_reg;
                out_off_reg      <= off_final;
                out_bad_reg      <= 1'b0;
                out_last_reg     <= records_done_next == pair_count_reg;
                prev_off_reg     <= off_final;
                prev_id_reg      <= cur_id_reg;
                records_done_reg <= records_done_next;
            end

            if (cmd.emit_bad)
            begin
                out_id_reg   <= '0;
                out_off_reg  <= '0;
                out_bad_reg  <= 1'b1;
                out_last_reg <= 1'b0;
            end
        end
    end

    assign decoded_id     = out_id_reg;
    assign decoded_offset = out_off_reg;
    assign bad_type       = out_bad_reg;
    assign last_pair      = out_last_reg;

endmodule

/* rtl/core/dpsd_ctrl.sv */
// Controller state machine: record parsing phases, divider sequencing and output handshake.
module dpsd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  dpsd_pkg::dp_status_t status,
    output dpsd_pkg::dp_cmd_t    cmd
);
    import dpsd_pkg::*;

    typedef enum logic [2:0] {
        ST_TYPE,
        ST_ID,
        ST_IDFIN,
        ST_OFF,
        ST_DIV,
        ST_CALC,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   halted_reg;
    logic   halted_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   accept;

    assign slot_free = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        unique case (state_reg)
            ST_TYPE:        s_tready = halted_reg || slot_free;
            ST_ID, ST_OFF:  s_tready = 1'b1;
            default:        s_tready = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_TYPE:
            begin
                // After a bad type byte every item is dropped until reset.
                if (accept && !halted_reg)
                begin
                    if (status.type_bad)
                    begin
                        cmd.emit_bad   = 1'b1;
                        halted_next    = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.load_type = 1'b1;
                        state_next    = status.type_id_empty ? ST_IDFIN : ST_ID;
                    end
                end
            end
            ST_ID:
            begin
                if (accept)
                begin
                    cmd.load_byte = 1'b1;
                    if (status.id_done)
                    begin
                        state_next = ST_IDFIN;
                    end
                end
            end
            ST_IDFIN:
            begin
                cmd.finish_id = 1'b1;
                if (!status.off_empty)
                begin
                    state_next = ST_OFF;
                end
                else if (status.scaled)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_CALC;
                end
            end
            ST_OFF:
            begin
                if (accept)
                begin
                    cmd.load_byte = 1'b1;
                    if (status.off_done)
                    begin
                        cmd.div_start = status.scaled;
                        state_next    = status.scaled ? ST_DIV : ST_CALC;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_TYPE;
                end
            end
            default:
            begin
                state_next = ST_TYPE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TYPE;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    // A type byte is only taken while the result register can absorb a bad-type result.
    a_type_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && !halted_reg && state_reg == ST_TYPE) |-> slot_free)
        else $error("type byte accepted with output register busy");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    a_halt_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> out_valid_reg)
        else $error("halt entered without a bad-type result");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> (state_reg == ST_DIV || state_reg == ST_CALC))
        else $error("divider wait left to an unexpected state");
`endif

endmodule

/* rtl/core/delta_pair_stream_decoder_top.sv */
// Top level of the delta pair stream decoder: controller, datapath and port packing.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one stream byte per item.
//   Each record is a type byte followed by the little-endian id and offset operands.
//   The master channel (m_tvalid, m_tready, m_tdata, m_tuser, m_tlast) gives one
//   item per completed record: m_tdata holds the id and the scaled offset, m_tuser
//   flags a bad type byte and m_tlast marks the pair that reaches pair_count.
//   Registers are written through cfg_we, cfg_index and cfg_data while idle.
// Timing:
//   Operand bytes are taken one per cycle, but none in ST_IDFIN between id and offset.
//   The last offset byte leads to ST_CALC, then ST_EMIT, which registers the result
//   once the result register is free; with no offset bytes ST_IDFIN resolves the id
//   first. Type bit 7 adds ST_DIV for the 64-by-5 bit divider (eight quotient bits per
//   cycle). A bad type byte gives its result in the cycle after it is taken.
// Reset and stalls:
//   Reset clears all state, sets pointer_bytes to 8 and pair_count to 0.
//   While a result waits on m_tready, operand bytes keep flowing; a new type byte
//   or a record's completion waits until the result register is free.
module delta_pair_stream_decoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: stream_byte[7:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    // m_tdata: decoded_id[63:0], decoded_offset[127:64]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [127:0]                    m_tdata,
    // m_tuser: bad_type[0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [dpsd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dpsd_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [VALUE_W-1:0] decoded_id;
    logic [VALUE_W-1:0] decoded_offset;

    dpsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dpsd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .stream_byte    (s_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .decoded_id     (decoded_id),
        .decoded_offset (decoded_offset),
        .bad_type       (m_tuser),
        .last_pair      (m_tlast)
    );

    assign m_tdata = {decoded_offset, decoded_id};

endmodule

/* tb/dpsd_checker.sv */
// Stream monitor, pair predictor and result comparison for the delta pair stream decoder.
`timescale 1ns / 1ps

module dpsd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [127:0]                    m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [dpsd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              pending,
    output int                              fail_count,
    output int                              pairs_checked
);

    import dpsd_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef enum logic [1:0] {
        AWAIT_TYPE,
        GET_ID,
        GET_OFFSET
    } stage_t;

    typedef struct {
        logic [63:0] id;
        logic [63:0] offset;
        logic        bad;
        logic        last;
    } pair_t;

    pair_t expected_pairs[$];

    // Predictor copy of the decoder state and registers.
    logic [4:0]  ptr_size;
    logic [31:0] table_len;
    stage_t      stage;
    logic [7:0]  rec_kind;
    int unsigned op_index;
    logic [63:0] op_value;
    logic [63:0] last_id;
    logic [63:0] last_offset;
    logic [63:0] pending_id;
    logic [31:0] record_tally;
    logic        stopped;

    initial begin
        fail_count    = 0;
        pairs_checked = 0;
        pending       = 0;
    end

    function automatic int operand_len(input logic [2:0] form);
        case (form_t'(form))
            FORM_RAW:             return 8;
            FORM_INC:             return 0;
            FORM_ADD8, FORM_SUB8: return 1;
            FORM_ABS32:           return 4;
            default:              return 2;
        endcase
    endfunction

    function automatic logic [63:0] apply_delta(
        input logic [2:0]  form,
        input logic [63:0] prev,
        input logic [63:0] value
    );
        case (form_t'(form))
            FORM_INC:              return prev + 64'd1;
            FORM_ADD8, FORM_ADD16: return prev + value;
            FORM_SUB8, FORM_SUB16: return prev - value;
            default:               return value;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic clear_state();
        ptr_size     = POINTER_BYTES_RESET;
        table_len    = '0;
        stage        = AWAIT_TYPE;
        rec_kind     = '0;
        op_index     = 0;
        op_value     = '0;
        last_id      = '0;
        last_offset  = '0;
        pending_id   = '0;
        record_tally = '0;
        stopped      = 1'b0;
        expected_pairs.delete();
    endtask

    task automatic close_record();
        logic [63:0] divisor;
        logic [63:0] base;
        logic [63:0] off;
        pair_t       p;
        // A zero pointer size behaves as one, so the offset is left unscaled.
        divisor = (ptr_size == 5'd0) ? 64'd1 : {59'd0, ptr_size};
        base = rec_kind[7] ? last_offset / divisor : last_offset;
        off = apply_delta(rec_kind[6:4], base, op_value);
        if (rec_kind[7])
            off = off * divisor;
        last_offset  = off;
        last_id      = pending_id;
        record_tally = record_tally + 32'd1;
        stage        = AWAIT_TYPE;
        op_index     = 0;
        op_value     = '0;
        p.id     = pending_id;
        p.offset = off;
        p.bad    = 1'b0;
        p.last   = (record_tally == table_len);
        expected_pairs.push_back(p);
    endtask

    task automatic resolve_id();
        pending_id = apply_delta(rec_kind[2:0], last_id, op_value);
        stage      = GET_OFFSET;
        op_index   = 0;
        op_value   = '0;
        if (operand_len(rec_kind[6:4]) == 0)
            close_record();
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int    need;
        pair_t p;
        if (stopped)
            return;
        if (stage != AWAIT_TYPE) begin
            need = (stage == GET_ID) ? operand_len(rec_kind[2:0]) : operand_len(rec_kind[6:4]);
            op_value = op_value | ({56'd0, b} << (8 * op_index));
            if (op_index + 1 >= need) begin
                if (stage == GET_ID)
                    resolve_id();
                else
                    close_record();
            end
            else begin
                op_index = op_index + 1;
            end
        end
        else begin
            rec_kind = b;
            if (b[3:0] > ID_FORM_MAX) begin
                // A bad type byte reports once and then the decoder stays silent.
                stopped  = 1'b1;
                p.id     = '0;
                p.offset = '0;
                p.bad    = 1'b1;
                p.last   = 1'b0;
                expected_pairs.push_back(p);
            end
            else begin
                stage    = GET_ID;
                op_index = 0;
                op_value = '0;
                if (operand_len(b[2:0]) == 0)
                    resolve_id();
            end
        end
    endtask

    task automatic check_pair();
        pair_t want;
        if (expected_pairs.size() == 0) begin
            report_mismatch($sformatf("pair with none expected: id %h offset %h bad %b",
                                      m_tdata[63:0], m_tdata[127:64], m_tuser));
            return;
        end
        want = expected_pairs.pop_front();
        pairs_checked++;
        if (m_tdata[63:0] !== want.id)
            report_mismatch($sformatf("decoded_id %h, want %h", m_tdata[63:0], want.id));
        if (m_tdata[127:64] !== want.offset)
            report_mismatch($sformatf("decoded_offset %h, want %h",
                                      m_tdata[127:64], want.offset));
        if (m_tuser !== want.bad)
            report_mismatch($sformatf("bad_type %b, want %b", m_tuser, want.bad));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("last_pair %b, want %b", m_tlast, want.last));
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            clear_state();
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_POINTER_BYTES)
                    ptr_size = cfg_data[PTR_W-1:0];
                else
                    table_len = cfg_data[COUNT_W-1:0];
            end
            if (m_tvalid && m_tready)
                check_pair();
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            pending <= expected_pairs.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Testbench top: clock, reset, record stream stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_top;

    import dpsd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [127:0]          m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int pending;
    int fail_count;
    int pairs_checked;
    int tx_idle_pct;
    int rx_idle_pct;
    int records_fed;
    int bytes_fed;
    int cycle_count = 0;

    delta_pair_stream_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dpsd_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .fail_count    (fail_count),
        .pairs_checked (pairs_checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d pairs outstanding", cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int operand_count(input logic [2:0] form);
        case (form_t'(form))
            FORM_RAW:             return 8;
            FORM_INC:             return 0;
            FORM_ADD8, FORM_SUB8: return 1;
            FORM_ABS32:           return 4;
            default:              return 2;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_fed++;
    endtask

    task automatic send_record(input logic [7:0] kind, input fill_t fill);
        int          n;
        logic [7:0]  b;
        n = operand_count(kind[2:0]) + operand_count(kind[6:4]);
        send_byte(kind);
        repeat (n) begin
            case (fill)
                FILL_ONES:  b = 8'hFF;
                FILL_ZEROS: b = 8'h00;
                default: begin
                    // Lean on all-zero and all-one bytes to reach the wrap cases.
                    case ($urandom_range(7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom);
                    endcase
                end
            endcase
            send_byte(b);
        end
        records_fed++;
    endtask

    task automatic send_random_records(input int n_bytes);
        int          stop_at;
        logic [7:0]  kind;
        stop_at = bytes_fed + n_bytes;
        while (bytes_fed < stop_at) begin
            kind    = 8'($urandom);
            kind[3] = 1'b0;
            send_record(kind, FILL_RANDOM);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // The decoder may still be busy after the last pair, so let it settle before writing.
    task automatic configure(input logic [4:0] ptr, input logic [31:0] count);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_POINTER_BYTES, ($urandom & 32'hFFFF_FFE0) | {27'd0, ptr});
        write_reg(CFG_PAIR_COUNT, count);
    endtask

    initial
    begin
        logic [7:0] kind;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_POINTER_BYTES;
        cfg_data    = '0;
        records_fed = 0;
        bytes_fed   = 0;
        tx_idle_pct = 37;
        rx_idle_pct = 60;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every id form and every offset form once, with the reset register values.
        send_record(8'h00, FILL_ONES);
        send_record(8'h11, FILL_RANDOM);
        send_record(8'hB2, FILL_ONES);
        send_record(8'h23, FILL_RANDOM);
        send_record(8'h54, FILL_RANDOM);
        send_record(8'hC5, FILL_ONES);
        send_record(8'h76, FILL_ZEROS);
        send_record(8'hE7, FILL_ONES);

        configure(5'd1, records_fed + 5);
        send_random_records(80);

        tx_idle_pct = 60;
        rx_idle_pct = 37;
        configure(5'd16, 32'hFFFF_FFFF);
        send_random_records(40);
        drain_results();
        send_random_records(40);

        configure(5'd0, records_fed + 3);
        send_random_records(80);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(5'd31, records_fed + 1);
        send_random_records(80);

        configure(5'($urandom_range(2, 31)), records_fed + $urandom_range(1, 12));
        send_random_records(80);

        // A bad type byte halts the decoder; the bytes after it must give nothing.
        kind    = 8'($urandom);
        kind[3] = 1'b1;
        send_byte(kind);
        repeat (5) send_byte(8'($urandom));

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Fed %0d bytes in %0d records and checked %0d pairs.",
                 bytes_fed, records_fed, pairs_checked);
        $display("Pointer sizes 8, 1, 16, 0, 31 and one random, ending on a bad type byte.");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
